// File: src/rtpv_pkg.sv
`timescale 1ns / 1ps
package rtpv_pkg;

  // Frame geometry
  localparam int unsigned ROWS    = 10;
  localparam int unsigned COLUMNS = 20;

  // Header layout: 12-byte RTP header, 2-byte extended sequence, 6 bytes per row
  localparam int unsigned RTP_FIXED_BYTES = 14;
  localparam int unsigned HDR_BYTES       = RTP_FIXED_BYTES + 6 * ROWS;
  localparam int unsigned HDR_LAST_CNT    = HDR_BYTES - 4 * ((HDR_BYTES - 1) / 4);

  localparam int unsigned POS_W = $clog2(HDR_BYTES + 4);
  localparam int unsigned ROW_W = $clog2(ROWS + 2);
  localparam int unsigned WID_W = $clog2(COLUMNS + 1);
  localparam int unsigned PIX_W = $clog2(COLUMNS * ROWS + 1);

  localparam logic [7:0] RTP_VER_BYTE = 8'h80;
  localparam logic [7:0] MARKER_BIT   = 8'h80;
  localparam logic [7:0] CONT_BIT     = 8'h80;
  localparam logic [6:0] PT_RESET     = 7'd96;

  // Operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Configuration register indexes
  localparam logic REG_SSRC = 1'b0;
  localparam logic REG_PT   = 1'b1;

  // Command queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  typedef struct packed {
    logic        is_pixel;
    logic        pix_end;
    logic [23:0] rgb;
    logic [31:0] ts;
    logic [31:0] seq;
    logic [4:0]  col;
    logic [15:0] len;
    logic        no_pixels;
  } cmd_t;

endpackage

// File: src/rtpv_front.sv
`timescale 1ns / 1ps
module rtpv_front import rtpv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  logic        operation_i,
  input  logic [4:0]  start_column_i,
  input  logic [4:0]  region_width_i,
  input  logic [31:0] timestamp_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output logic        cmd_push_o,
  output cmd_t        cmd_o
);

  logic             open_q, open_d;
  logic [PIX_W-1:0] left_q, left_d;
  logic [31:0]      seq_q, seq_d;

  logic [7:0]       col_ext, w_raw, remain, w_sel;
  logic [WID_W-1:0] w_clamp;
  logic [15:0]      len;
  logic             is_start, pix_end;

  assign col_ext  = 8'(start_column_i);
  assign w_raw    = 8'(region_width_i);
  assign remain   = 8'(COLUMNS) - col_ext;
  assign is_start = (operation_i == OP_START);
  assign pix_end  = (left_q == PIX_W'(1));

  always_comb begin
    priority if (col_ext >= 8'(COLUMNS)) begin
      w_sel = 8'd0;
    end else if (w_raw > remain) begin
      w_sel = remain;
    end else begin
      w_sel = w_raw;
    end
  end

  assign w_clamp = WID_W'(w_sel);
  assign len     = 16'({w_clamp, 1'b0}) + 16'(w_clamp);

  always_comb begin
    cmd_o.is_pixel  = !is_start;
    cmd_o.pix_end   = pix_end;
    cmd_o.rgb       = {red_i, green_i, blue_i};
    cmd_o.ts        = timestamp_i;
    cmd_o.seq       = seq_q;
    cmd_o.col       = start_column_i;
    cmd_o.len       = len;
    cmd_o.no_pixels = (w_clamp == '0);
  end

  // drop pixels with no open packet
  assign cmd_push_o = item_valid_i && (is_start || open_q);

  always_comb begin
    open_d = open_q;
    left_d = left_q;
    seq_d  = seq_q;
    if (item_valid_i) begin
      if (is_start) begin
        if (w_clamp == '0) begin
          open_d = 1'b0;
          left_d = '0;
          seq_d  = seq_q + 32'd1;
        end else begin
          open_d = 1'b1;
          left_d = PIX_W'(w_clamp) * PIX_W'(ROWS);
        end
      end else if (open_q) begin
        left_d = left_q - PIX_W'(1);
        if (pix_end) begin
          open_d = 1'b0;
          seq_d  = seq_q + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      left_q <= '0;
      seq_q  <= '0;
    end else begin
      open_q <= open_d;
      left_q <= left_d;
      seq_q  <= seq_d;
    end
  end

  a_closed_no_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> left_q == '0)
    else $error("pixel count left over with no open packet");

endmodule

// File: src/rtpv_fifo.sv
`timescale 1ns / 1ps
module rtpv_fifo import rtpv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wr_data_i,
  output logic full_o,
  input  logic rd_i,
  output cmd_t rd_data_o,
  output logic empty_o
);

  cmd_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] count_q;

  assign full_o    = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (rd_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      unique case ({wr_i, rd_i})
        2'b10:   count_q <= count_q + FIFO_CNT_W'(1);
        2'b01:   count_q <= count_q - FIFO_CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("command queue count beyond depth");

endmodule

// File: src/rtpv_back.sv
`timescale 1ns / 1ps
module rtpv_back import rtpv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fifo_empty_i,
  input  cmd_t        fifo_cmd_i,
  output logic        fifo_pop_o,
  input  logic [31:0] ssrc_i,
  input  logic [6:0]  pt_i,
  input  logic        pop,
  output logic        empty,
  output logic [31:0] data_word_o,
  output logic [2:0]  byte_count_o,
  output logic        last_o
);

  logic             hdr_act_q, hdr_act_d;
  cmd_t             hdr_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [2:0]       off_q, off_d;

  logic             out_valid_q, out_valid_d;
  logic [31:0]      out_data_q, out_data_d;
  logic [2:0]       out_cnt_q, out_cnt_d;
  logic             out_last_q, out_last_d;

  logic             adv, last_word, load_hdr;
  logic [31:0]      hdr_word;
  logic [2:0]       hdr_cnt;
  logic [POS_W-1:0] p;
  logic [3:0]       o;
  logic [ROW_W-1:0] r;
  logic [7:0]       by;

  assign adv        = !out_valid_q || pop;
  assign fifo_pop_o = adv && !hdr_act_q && !fifo_empty_i;
  assign load_hdr   = fifo_pop_o && !fifo_cmd_i.is_pixel;
  assign last_word  = (pos_q + POS_W'(4)) >= POS_W'(HDR_BYTES);
  assign hdr_cnt    = last_word ? 3'(POS_W'(HDR_BYTES) - pos_q) : 3'd4;

  // assemble one header word; bytes past the header end are zero
  always_comb begin
    hdr_word = '0;
    p  = '0;
    o  = '0;
    r  = '0;
    by = '0;
    for (int b = 0; b < 4; b++) begin
      p = pos_q + POS_W'(b);
      o = {1'b0, off_q} + 4'(b);
      r = row_q;
      if (o >= 4'd6) begin
        o = o - 4'd6;
        r = row_q + ROW_W'(1);
      end
      if (pos_q < POS_W'(16)) begin
        unique case (p[3:0])
          4'd0:    by = RTP_VER_BYTE;
          4'd1:    by = MARKER_BIT | {1'b0, pt_i};
          4'd2:    by = hdr_q.seq[15:8];
          4'd3:    by = hdr_q.seq[7:0];
          4'd4:    by = hdr_q.ts[31:24];
          4'd5:    by = hdr_q.ts[23:16];
          4'd6:    by = hdr_q.ts[15:8];
          4'd7:    by = hdr_q.ts[7:0];
          4'd8:    by = ssrc_i[31:24];
          4'd9:    by = ssrc_i[23:16];
          4'd10:   by = ssrc_i[15:8];
          4'd11:   by = ssrc_i[7:0];
          4'd12:   by = hdr_q.seq[31:24];
          4'd13:   by = hdr_q.seq[23:16];
          4'd14:   by = hdr_q.len[15:8];
          default: by = hdr_q.len[7:0];
        endcase
      end else begin
        unique case (o[2:0])
          3'd0:    by = hdr_q.len[15:8];
          3'd1:    by = hdr_q.len[7:0];
          3'd3:    by = 8'(r);
          3'd4:    by = (r != ROW_W'(ROWS - 1)) ? CONT_BIT : 8'h00;
          3'd5:    by = {3'b000, hdr_q.col};
          default: by = 8'h00;
        endcase
      end
      if (p >= POS_W'(HDR_BYTES)) begin
        by = 8'h00;
      end
      hdr_word[31 - 8 * b -: 8] = by;
    end
  end

  always_comb begin
    hdr_act_d   = hdr_act_q;
    pos_d       = pos_q;
    row_d       = row_q;
    off_d       = off_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;
    if (adv) begin
      out_valid_d = 1'b0;
      if (hdr_act_q) begin
        out_valid_d = 1'b1;
        out_data_d  = hdr_word;
        out_cnt_d   = hdr_cnt;
        out_last_d  = last_word && hdr_q.no_pixels;
        pos_d       = pos_q + POS_W'(4);
        // track row and byte offset of the next word inside the line headers
        if (pos_q == POS_W'(12)) begin
          row_d = '0;
          off_d = 3'd2;
        end else if (pos_q >= POS_W'(16)) begin
          if (off_q >= 3'd2) begin
            off_d = off_q - 3'd2;
            row_d = row_q + ROW_W'(1);
          end else begin
            off_d = off_q + 3'd4;
          end
        end
        if (last_word) begin
          hdr_act_d = 1'b0;
        end
      end else if (!fifo_empty_i) begin
        if (fifo_cmd_i.is_pixel) begin
          out_valid_d = 1'b1;
          out_data_d  = {fifo_cmd_i.rgb, 8'h00};
          out_cnt_d   = 3'd3;
          out_last_d  = fifo_cmd_i.pix_end;
        end else begin
          hdr_act_d = 1'b1;
          pos_d     = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_act_q   <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
    end else begin
      hdr_act_q   <= hdr_act_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q      <= row_d;
    off_q      <= off_d;
    out_data_q <= out_data_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
    if (load_hdr) begin
      hdr_q <= fifo_cmd_i;
    end
  end

  assign empty        = !out_valid_q;
  assign data_word_o  = out_data_q;
  assign byte_count_o = out_cnt_q;
  assign last_o       = out_last_q;

  a_pos_in_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_act_q |-> pos_q < POS_W'(HDR_BYTES))
    else $error("header position past header end");

  a_short_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_cnt_q != 3'd4 |->
      out_cnt_q == 3'd3 || out_cnt_q == 3'(HDR_LAST_CNT))
    else $error("unexpected byte count on output word");

  a_pixel_low_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(fifo_pop_o) && $past(fifo_cmd_i.is_pixel) |-> out_valid_q && out_cnt_q == 3'd3)
    else $error("popped pixel did not reach the output register");

endmodule

// File: src/rtp_raw_video_packetizer.sv
`timescale 1ns / 1ps
// Raw-video RTP packetizer (RFC 4175 style line headers).
// Input queue: drive the item on the field ports with push high; it is taken
// at a clock edge where full is low. A start item (operation 0) opens a
// packet; pixel items (operation 1) follow, one RGB word each. Pixels with no
// open packet are dropped; a start abandons any open packet.
// Output queue: while empty is low, data_word_o/byte_count_o/last_o hold the
// oldest word; pop takes it. last_o marks the final word of a packet.
// A pixel passes the command queue and the output register. A start item
// yields 14+6*ROWS header bytes as 19 words (default ROWS), one per cycle
// while pop keeps up, after the back end loads the start. Throughput: one
// pixel per cycle while full is low. A start holds the back end while it
// sends its header; meanwhile the four-entry command queue takes the next
// items, and full rises once it holds four. When pop stays low the output
// word holds, the queue fills and full rises. Reset clears the sequence
// number, closes any packet, empties the queue, sets ssrc to 0 and payload
// type to 96. Configuration writes (cfg_we_i, cfg_addr_i 0 ssrc, 1 payload
// type) take effect at once; users must make them while idle, unenforced.
module rtp_raw_video_packetizer import rtpv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic        operation_i,
  input  logic [4:0]  start_column_i,
  input  logic [4:0]  region_width_i,
  input  logic [31:0] timestamp_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] data_word_o,
  output logic [2:0]  byte_count_o,
  output logic        last_o
);

  logic [31:0] ssrc_q;
  logic [6:0]  pt_q;
  logic        item_valid, cmd_push, fifo_empty, fifo_pop;
  cmd_t        cmd_in, cmd_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ssrc_q <= '0;
      pt_q   <= PT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_SSRC: ssrc_q <= cfg_wdata_i;
        REG_PT:   pt_q   <= cfg_wdata_i[6:0];
        default:  ssrc_q <= ssrc_q;
      endcase
    end
  end

  assign item_valid = push && !full;

  rtpv_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .operation_i    (operation_i),
    .start_column_i (start_column_i),
    .region_width_i (region_width_i),
    .timestamp_i    (timestamp_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .cmd_push_o     (cmd_push),
    .cmd_o          (cmd_in)
  );

  rtpv_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_push),
    .wr_data_i (cmd_in),
    .full_o    (full),
    .rd_i      (fifo_pop),
    .rd_data_o (cmd_out),
    .empty_o   (fifo_empty)
  );

  rtpv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .fifo_cmd_i   (cmd_out),
    .fifo_pop_o   (fifo_pop),
    .ssrc_i       (ssrc_q),
    .pt_i         (pt_q),
    .pop          (pop),
    .empty        (empty),
    .data_word_o  (data_word_o),
    .byte_count_o (byte_count_o),
    .last_o       (last_o)
  );

endmodule

// File: tb/rtpv_packet_checker.sv
`timescale 1ns / 1ps
module rtpv_packet_checker import rtpv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        push_i,
  input  logic        full_i,
  input  logic        operation_i,
  input  logic [4:0]  start_column_i,
  input  logic [4:0]  region_width_i,
  input  logic [31:0] timestamp_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_i,
  output int          pending_o,
  output int          errors_o,
  output int          starts_o,
  output int          pixels_o,
  output int          dropped_o,
  output int          words_o,
  output int          packets_o
);

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  count;
    logic        last;
  } pkt_word_t;

  pkt_word_t   pkt_words_q[$];
  logic [31:0] ssrc;
  logic [6:0]  ptype;
  logic [31:0] seq_num;
  logic        pkt_open;
  int unsigned pix_left;

  // Queue the header words of a new packet and open it unless its clamped width is zero.
  task automatic queue_header(input logic [4:0] col, input logic [4:0] width,
                              input logic [31:0] ts);
    logic [7:0]  hdr [HDR_BYTES];
    int unsigned w;
    logic [15:0] len;
    int unsigned r;
    int unsigned base;
    int unsigned cnt;
    int unsigned b;
    pkt_word_t   hw;
    if (col >= COLUMNS) begin
      w = 0;
    end else if (width > COLUMNS - col) begin
      w = COLUMNS - col;
    end else begin
      w = width;
    end
    len = 16'(w * 3);
    hdr[0]  = RTP_VER_BYTE;
    hdr[1]  = MARKER_BIT | {1'b0, ptype};
    hdr[2]  = seq_num[15:8];
    hdr[3]  = seq_num[7:0];
    hdr[4]  = ts[31:24];
    hdr[5]  = ts[23:16];
    hdr[6]  = ts[15:8];
    hdr[7]  = ts[7:0];
    hdr[8]  = ssrc[31:24];
    hdr[9]  = ssrc[23:16];
    hdr[10] = ssrc[15:8];
    hdr[11] = ssrc[7:0];
    hdr[12] = seq_num[31:24];
    hdr[13] = seq_num[23:16];
    for (r = 0; r < ROWS; r++) begin
      base          = RTP_FIXED_BYTES + 6 * r;
      hdr[base]     = len[15:8];
      hdr[base + 1] = len[7:0];
      hdr[base + 2] = 8'(r >> 8);
      hdr[base + 3] = 8'(r);
      // offset is five bits wide, so only the continuation flag can be set here
      hdr[base + 4] = (r != ROWS - 1) ? CONT_BIT : 8'h00;
      hdr[base + 5] = {3'b000, col};
    end
    for (base = 0; base < HDR_BYTES; base += 4) begin
      cnt     = (HDR_BYTES - base >= 4) ? 4 : HDR_BYTES - base;
      hw.data = '0;
      for (b = 0; b < cnt; b++) begin
        hw.data[31 - 8 * b -: 8] = hdr[base + b];
      end
      hw.count = 3'(cnt);
      hw.last  = (base + cnt >= HDR_BYTES) && (w == 0);
      pkt_words_q.push_back(hw);
    end
    if (w == 0) begin
      pkt_open = 1'b0;
      pix_left = 0;
      seq_num++;
    end else begin
      pkt_open = 1'b1;
      pix_left = w * ROWS;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pkt_word_t want;
    if (!rst_ni) begin
      pkt_words_q.delete();
      ssrc      = '0;
      ptype     = PT_RESET;
      seq_num   = '0;
      pkt_open  = 1'b0;
      pix_left  = 0;
      pending_o = 0;
      errors_o  = 0;
      starts_o  = 0;
      pixels_o  = 0;
      dropped_o = 0;
      words_o   = 0;
      packets_o = 0;
    end else begin
      if (pop_i && !empty_i) begin
        words_o++;
        if (last_i) packets_o++;
        if (pkt_words_q.size() == 0) begin
          $error("data_word 0x%08h arrived with no request waiting", data_word_i);
          errors_o++;
        end else begin
          want = pkt_words_q.pop_front();
          if (data_word_i !== want.data) begin
            $error("data_word: expected 0x%08h, got 0x%08h", want.data, data_word_i);
            errors_o++;
          end
          if (byte_count_i !== want.count) begin
            $error("byte_count: expected %0d, got %0d", want.count, byte_count_i);
            errors_o++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last_i);
            errors_o++;
          end
        end
      end
      if (push_i && !full_i) begin
        if (operation_i == OP_START) begin
          starts_o++;
          queue_header(start_column_i, region_width_i, timestamp_i);
        end else if (!pkt_open) begin
          dropped_o++;
        end else begin
          pixels_o++;
          pix_left--;
          want.data  = {red_i, green_i, blue_i, 8'h00};
          want.count = 3'd3;
          want.last  = (pix_left == 0);
          pkt_words_q.push_back(want);
          if (want.last) begin
            pkt_open = 1'b0;
            seq_num++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_SSRC: ssrc  = cfg_wdata_i;
          REG_PT:   ptype = cfg_wdata_i[6:0];
          default: ;
        endcase
      end
      pending_o = pkt_words_q.size();
    end
  end

endmodule

// File: tb/rtp_raw_video_packetizer_test.sv
`timescale 1ns / 1ps
module rtp_raw_video_packetizer_test;
  import rtpv_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 400;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_addr_i;
  logic [31:0] cfg_wdata_i;
  logic        push;
  logic        full;
  logic        operation_i;
  logic [4:0]  start_column_i;
  logic [4:0]  region_width_i;
  logic [31:0] timestamp_i;
  logic [7:0]  red_i;
  logic [7:0]  green_i;
  logic [7:0]  blue_i;
  logic        empty;
  logic        pop;
  logic [31:0] data_word_o;
  logic [2:0]  byte_count_o;
  logic        last_o;

  int pending;
  int errors;
  int starts;
  int pixels;
  int dropped;
  int words;
  int packets;

  int   send_calm;
  int   recv_calm;
  int   idle_count;
  logic hold_req;
  logic hold_done;

  rtp_raw_video_packetizer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .operation_i    (operation_i),
    .start_column_i (start_column_i),
    .region_width_i (region_width_i),
    .timestamp_i    (timestamp_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .empty          (empty),
    .pop            (pop),
    .data_word_o    (data_word_o),
    .byte_count_o   (byte_count_o),
    .last_o         (last_o)
  );

  rtpv_packet_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push_i         (push),
    .full_i         (full),
    .operation_i    (operation_i),
    .start_column_i (start_column_i),
    .region_width_i (region_width_i),
    .timestamp_i    (timestamp_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .empty_i        (empty),
    .pop_i          (pop),
    .data_word_i    (data_word_o),
    .byte_count_i   (byte_count_o),
    .last_i         (last_o),
    .pending_o      (pending),
    .errors_o       (errors),
    .starts_o       (starts),
    .pixels_o       (pixels),
    .dropped_o      (dropped),
    .words_o        (words),
    .packets_o      (packets)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic write_reg(input logic addr, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_item(input logic op, input logic [4:0] col, input logic [4:0] width,
                           input logic [31:0] ts, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b);
    int gap;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else begin
      gap = idle_cycles();
      if ($urandom_range(0, 19) == 0) send_calm = $urandom_range(20, 50);
    end
    if (gap > 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push           <= 1'b1;
    operation_i    <= op;
    start_column_i <= col;
    region_width_i <= width;
    timestamp_i    <= ts;
    red_i          <= r;
    green_i        <= g;
    blue_i         <= b;
    do @(posedge clk_i); while (full);
  endtask

  task automatic send_packet(input logic [4:0] col, input logic [4:0] width, input int npix);
    send_item(OP_START, col, width, $urandom, 8'($urandom), 8'($urandom), 8'($urandom));
    repeat (npix) begin
      send_item(OP_PIXEL, 5'($urandom), 5'($urandom), $urandom,
                8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // Hold the sender until every expected word has come out, then let the block settle.
  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic random_phase(input int target);
    int          sent;
    int          r;
    int unsigned w;
    int          npix;
    logic [4:0]  col;
    logic [4:0]  width;
    logic        abandoned;
    sent      = 0;
    abandoned = 1'b0;
    while (sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 90) begin
        if (r < 65) begin
          col   = 5'($urandom_range(0, COLUMNS - 1));
          width = 5'($urandom_range(1, 3));
        end else if (r < 75) begin
          // any width, near the right edge so the clamp keeps the packet short
          col   = 5'($urandom_range(COLUMNS - 4, COLUMNS - 1));
          width = 5'($urandom);
        end else if ($urandom_range(0, 1) == 0) begin
          col   = 5'($urandom_range(COLUMNS, 31));
          width = 5'($urandom);
        end else begin
          col   = 5'($urandom_range(0, COLUMNS - 1));
          width = 5'd0;
        end
        if (col >= COLUMNS) begin
          w = 0;
        end else begin
          w = (width > COLUMNS - col) ? COLUMNS - col : width;
        end
        npix = w * ROWS;
        if (r >= 55 && r < 65 && w > 0) npix = $urandom_range(0, npix - 1);
        abandoned = (npix < w * ROWS);
        send_packet(col, width, npix);
        sent += 1 + npix;
      end else if (!abandoned) begin
        // stray pixels: nothing open, so they must vanish
        repeat ($urandom_range(1, 3)) begin
          send_item(OP_PIXEL, 5'($urandom), 5'($urandom), $urandom,
                    8'($urandom), 8'($urandom), 8'($urandom));
        end
      end
    end
  endtask

  // Result side: random pops, plus one long hold-off once requested.
  initial begin : receiver
    int gap;
    pop       = 1'b0;
    recv_calm = 0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        @(negedge clk_i);
        pop <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else begin
        if (recv_calm > 0) begin
          recv_calm--;
          gap = 0;
        end else begin
          gap = idle_cycles();
          if ($urandom_range(0, 19) == 0) recv_calm = $urandom_range(20, 50);
        end
        if (gap > 0) begin
          @(negedge clk_i);
          pop <= 1'b0;
          repeat (gap - 1) @(negedge clk_i);
        end
      end
      @(negedge clk_i);
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_count <= 0;
    end else if (idle_count == STALL_LIMIT) begin
      $display("FAIL rtp_raw_video_packetizer");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin : stimulus
    int i;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_addr_i     = REG_SSRC;
    cfg_wdata_i    = '0;
    push           = 1'b0;
    operation_i    = OP_START;
    start_column_i = '0;
    region_width_i = '0;
    timestamp_i    = '0;
    red_i          = '0;
    green_i        = '0;
    blue_i         = '0;
    send_calm      = 0;
    hold_req       = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_reg(REG_SSRC, 32'hFFFF_FFFF);
    write_reg(REG_PT, {25'($urandom), 7'h7F});

    // stray pixel before any packet
    send_item(OP_PIXEL, 5'h1F, 5'h1F, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
    // one-column region, pixel bytes at both extremes
    send_item(OP_START, 5'd0, 5'd1, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00);
    for (i = 0; i < ROWS; i++) begin
      send_item(OP_PIXEL, 5'd0, 5'd0, 32'h0, {8{i[0]}}, {8{i[0]}}, {8{i[0]}});
    end
    // width clamped to the last column, then abandoned
    send_item(OP_START, 5'(COLUMNS - 1), 5'(COLUMNS), 32'h0, 8'hFF, 8'hFF, 8'hFF);
    repeat (3) send_item(OP_PIXEL, 5'd0, 5'd0, 32'h0, 8'h5A, 8'hA5, 8'h3C);
    // empty regions: offset past the line and zero width
    send_item(OP_START, 5'h1F, 5'h1F, 32'hA5A5_5A5A, 8'h00, 8'h00, 8'h00);
    send_item(OP_START, 5'(COLUMNS), 5'd1, 32'h1234_5678, 8'h00, 8'h00, 8'h00);
    send_item(OP_START, 5'd5, 5'd0, 32'h8000_0001, 8'h00, 8'h00, 8'h00);
    send_item(OP_PIXEL, 5'd0, 5'd0, 32'h0, 8'h00, 8'h00, 8'h00);
    drain();

    write_reg(REG_SSRC, 32'h0);
    write_reg(REG_PT, 32'h0);
    hold_req = 1'b1;
    random_phase(60);
    drain();

    write_reg(REG_SSRC, $urandom);
    write_reg(REG_PT, $urandom);
    random_phase(60);
    drain();

    write_reg(REG_PT, {25'($urandom), PT_RESET});
    // full-width region, left open after its first line
    send_packet(5'd0, 5'(COLUMNS), COLUMNS);
    random_phase(40);
    drain();

    $display("Covered %0d starts, %0d pixels in open packets, %0d stray pixels dropped;",
             starts, pixels, dropped);
    $display("checked %0d words in %0d closed packets over four register settings.",
             words, packets);
    if (errors == 0 && pending == 0) begin
      $display("PASS rtp_raw_video_packetizer");
    end else begin
      $display("FAIL rtp_raw_video_packetizer");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/rtpv_pkg.sv
src/rtpv_front.sv
src/rtpv_fifo.sv
src/rtpv_back.sv
src/rtp_raw_video_packetizer.sv
tb/rtpv_packet_checker.sv
tb/rtp_raw_video_packetizer_test.sv
